// ===== hw/rtl/stpq_pkg.sv =====
// ----------------------------------------------------------------------------
// stpq_pkg
// Shared types and constants for the stable priority queue.
// ----------------------------------------------------------------------------
package stpq_pkg;

   localparam int DEPTH         = 16;
   localparam int PRIORITY_BITS = 16;
   localparam int TAG_BITS      = 8;
   localparam int COUNT_BITS    = $clog2(DEPTH + 1);
   localparam int OCC_BITS      = 5;

   // stream packing
   localparam int REQ_DATA_BITS = ((PRIORITY_BITS + TAG_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = PRIORITY_BITS + TAG_BITS + OCC_BITS;
   localparam int RSP_DATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef enum logic {
      MODE_INSERT = 1'b0,
      MODE_POP    = 1'b1
   } mode_type;

   typedef struct packed {
      logic [PRIORITY_BITS-1:0] prio;
      logic [TAG_BITS-1:0]      tag;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/stable_priority_queue.sv =====
// A result is registered and appears in the cycle after its request transfer.
// Throughput: one insert or pop per cycle unless a held result stalls; every cell
// compares against the new priority in parallel and shifts in the same cycle.
// Reset clears the occupancy count and the result valid flag; slot contents
// are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded sorted queue built as a row of shifting cells; FIFO among equals.
// ----------------------------------------------------------------------------
module stable_priority_queue
   import stpq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // priority_req, tag
   input  logic                     req_tuser,   // mode
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // out_priority, out_tag, occupancy
   output logic [1:0]               rsp_tuser    // pop_valid, rejected
);

   logic                  req_fire;
   logic                  is_pop;
   logic                  full;
   logic                  empty;
   cell_ctrl_type         ctrl;
   entry_type             new_entry;
   entry_type             cell_entry [DEPTH];
   logic [DEPTH-1:0]      cell_ge;
   logic [DEPTH-1:0]      cell_occ;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  pop_valid_ff, pop_valid_in;
   logic                  rejected_ff, rejected_in;
   entry_type             out_entry_ff, out_entry_in;
   logic [OCC_BITS-1:0]   occ_ff, occ_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign is_pop     = (mode_type'(req_tuser) == MODE_POP);
   assign full       = (count_ff == COUNT_BITS'(DEPTH));
   assign empty      = (count_ff == '0);

   assign new_entry.prio = req_tdata[PRIORITY_BITS-1:0];
   assign new_entry.tag  = req_tdata[PRIORITY_BITS +: TAG_BITS];

   assign ctrl.insert = req_fire && !is_pop && !full;
   assign ctrl.pop    = req_fire && is_pop && !empty;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic      left_ge;
      entry_type left_entry;
      entry_type right_entry;

      assign cell_occ[i] = (count_ff > COUNT_BITS'(i));

      if (i == 0) begin : g_head
         assign left_ge    = 1'b1;
         assign left_entry = new_entry;
      end else begin : g_body
         assign left_ge    = cell_ge[i-1];
         assign left_entry = cell_entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_mid
         assign right_entry = cell_entry[i+1];
      end

      stpq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_entry   (new_entry),
         .occupied    (cell_occ[i]),
         .left_ge     (left_ge),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .ge          (cell_ge[i]),
         .entry       (cell_entry[i])
      );
   end

   // next count
   always_comb begin
      count_in = count_ff;
      priority if (ctrl.insert) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      pop_valid_in = pop_valid_ff;
      rejected_in  = rejected_ff;
      out_entry_in = out_entry_ff;
      occ_in       = occ_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         pop_valid_in = ctrl.pop;
         rejected_in  = !is_pop && full;
         out_entry_in = ctrl.pop ? cell_entry[0] : '0;
         occ_in       = OCC_BITS'(count_in);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pop_valid_ff <= pop_valid_in;
      rejected_ff  <= rejected_in;
      out_entry_ff <= out_entry_in;
      occ_ff       <= occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - RSP_FIELD_BITS){1'b0}},
                        occ_ff, out_entry_ff.tag, out_entry_ff.prio};
   assign rsp_tuser  = {rejected_ff, pop_valid_ff};

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(DEPTH))
      else $error("occupancy above depth");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      count_ff >= COUNT_BITS'(2) |-> cell_entry[0].prio >= cell_entry[1].prio)
      else $error("head not highest priority");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |=> count_ff == $past(count_ff) - COUNT_BITS'(1))
      else $error("pop did not drop occupancy");

   a_reject_full: assert property (@(posedge clock) disable iff (reset)
      req_fire && !is_pop && full |=> rejected_ff && count_ff == COUNT_BITS'(DEPTH))
      else $error("full insert not rejected");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(pop_valid_ff && rejected_ff))
      else $error("pop_valid and rejected both set");
`endif

endmodule

// ===== hw/rtl/stpq_cell.sv =====
// ----------------------------------------------------------------------------
// stpq_cell
// One slot of the sorted queue: holds an entry, shifts right on insert
// below the insert point, shifts left on pop.
// ----------------------------------------------------------------------------
module stpq_cell
   import stpq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  entry_type     new_entry,
   input  logic          occupied,
   input  logic          left_ge,     // left neighbor stays (or this is the head)
   input  entry_type     left_entry,
   input  entry_type     right_entry,
   output logic          ge,          // this cell keeps its entry on insert
   output entry_type     entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // equal priority counts as "stays", so a new entry lands behind its peers
   assign ge    = occupied && (entry_ff.prio >= new_entry.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.pop) begin
         entry_in = right_entry;
      end else if (ctrl.insert) begin
         priority if (ge) begin
            entry_in = entry_ff;
         end else if (left_ge) begin
            entry_in = new_entry;
         end else begin
            entry_in = left_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
